// ===== sv/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray/sphere intersector
// Fixed-point formats, internal widths, register map and payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

   // Fixed-point formats
   localparam int POS_FRAC_BITS = 16;
   localparam int DIR_FRAC_BITS = 14;

   // Field widths
   localparam int POS_W  = 32;
   localparam int DIR_W  = 16;
   localparam int DIST_W = 31;

   // Internal widths
   localparam int P_W     = POS_W + 1;              // origin - center
   localparam int PD_W    = P_W + DIR_W;            // p * d
   localparam int S_W     = PD_W + 2;               // sum of three p * d
   localparam int PP_W    = 2 * P_W;                // p * p
   localparam int RR_W    = 2 * DIST_W;             // r * r
   localparam int CC_W    = PP_W + 2;               // |p|^2 - r^2
   localparam int SLO_W   = 32;                     // low slice of |s|
   localparam int SHI_W   = S_W - SLO_W;            // high slice of |s|
   localparam int DISC_W  = 2 * S_W + 2;            // discriminant
   localparam int Q_W     = DISC_W / 2;             // square root
   localparam int REM_W   = Q_W + 3;                // square root remainder
   localparam int NA_W    = Q_W + 2;                // -s -/+ q
   localparam int RT_W    = NA_W - DIR_FRAC_BITS;   // root in position scale
   localparam int TD_W    = DIST_W + 1 + DIR_W;     // t * d
   localparam int ACC_W   = TD_W + 1;               // o * 2^DIR + t * d
   localparam int PT_W    = ACC_W - DIR_FRAC_BITS;  // point before saturation

   // Stream word widths
   localparam int REQ_BITS  = 3 * POS_W + 3 * DIR_W + 2 * DIST_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = DIST_W + 3 * POS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [DIST_W-1:0] RADIUS_RESET = DIST_W'(1 << POS_FRAC_BITS);

   typedef enum logic [1:0] {
      REG_CENTER_X = 2'd0,
      REG_CENTER_Y = 2'd1,
      REG_CENTER_Z = 2'd2,
      REG_RADIUS   = 2'd3
   } reg_index_type;

   // One ray
   typedef struct packed {
      logic signed [POS_W-1:0] origin_x;
      logic signed [POS_W-1:0] origin_y;
      logic signed [POS_W-1:0] origin_z;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
      logic [DIST_W-1:0]       near_dist;
      logic [DIST_W-1:0]       far_dist;
   } ray_type;

   // Ray plus what the root stages need
   typedef struct packed {
      ray_type               ray;
      logic signed [S_W-1:0] s;
      logic                  miss;
   } item_type;

   // Saturate a point component to the signed position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PT_W-1:0] v);
      logic signed [PT_W-1:0] hi_lim;
      logic signed [PT_W-1:0] lo_lim;
      hi_lim = PT_W'({1'b0, {(POS_W-1){1'b1}}});
      lo_lim = -hi_lim - PT_W'(1);
      if (v > hi_lim) begin
         sat_pos = {1'b0, {(POS_W-1){1'b1}}};
      end else if (v < lo_lim) begin
         sat_pos = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         sat_pos = v[POS_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/rsi_setup.sv =====
// ----------------------------------------------------------------------------
// rsi_setup: discriminant pipeline
// Six stages: p = o - c, products, dot sums, |s|, split square, discriminant.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_setup import rsi_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire ray_type                  in_ray,
   input  wire logic signed [POS_W-1:0]  center_x,
   input  wire logic signed [POS_W-1:0]  center_y,
   input  wire logic signed [POS_W-1:0]  center_z,
   input  wire logic [DIST_W-1:0]        radius,
   output logic                          out_valid,
   output item_type                      out_item,
   output logic [DISC_W-1:0]             out_rad
);

   // stage 1: offset from center
   logic                  v1_ff;
   ray_type               ray1_ff;
   logic signed [P_W-1:0] px_ff, py_ff, pz_ff;
   logic [DIST_W-1:0]     r1_ff;
   // stage 2: products
   logic                   v2_ff;
   ray_type                ray2_ff;
   logic signed [PD_W-1:0] pdx_ff, pdy_ff, pdz_ff;
   logic signed [PP_W-1:0] ppx_ff, ppy_ff, ppz_ff;
   logic [RR_W-1:0]        rr_ff;
   // stage 3: sums
   logic                   v3_ff;
   ray_type                ray3_ff;
   logic signed [S_W-1:0]  s3_ff;
   logic signed [CC_W-1:0] cc3_ff;
   // stage 4: magnitude of s
   logic                   v4_ff;
   ray_type                ray4_ff;
   logic signed [S_W-1:0]  s4_ff;
   logic signed [CC_W-1:0] cc4_ff;
   logic [S_W-1:0]         sabs_ff;
   // stage 5: partial products of s * s
   logic                   v5_ff;
   ray_type                ray5_ff;
   logic signed [S_W-1:0]  s5_ff;
   logic signed [CC_W-1:0] cc5_ff;
   logic [2*SLO_W-1:0]     ll_ff;
   logic [SLO_W+SHI_W-1:0] lh_ff;
   logic [2*SHI_W-1:0]     hh_ff;
   // stage 6: discriminant
   logic                   v6_ff;
   item_type               item6_ff;
   logic [DISC_W-1:0]      rad6_ff;

   logic signed [PD_W-1:0]   pdx_in, pdy_in, pdz_in;
   logic signed [PP_W-1:0]   ppx_in, ppy_in, ppz_in;
   logic [RR_W-1:0]          rr_in;
   logic signed [S_W-1:0]    s3_in;
   logic signed [CC_W-1:0]   cc3_in;
   logic [SLO_W-1:0]         s_lo;
   logic [SHI_W-1:0]         s_hi;
   logic [DISC_W-1:0]        ss_sum;
   logic signed [DISC_W-1:0] cc_sh;
   logic signed [DISC_W-1:0] disc_in;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (en) begin
         ray1_ff <= in_ray;
         px_ff   <= P_W'(in_ray.origin_x) - P_W'(center_x);
         py_ff   <= P_W'(in_ray.origin_y) - P_W'(center_y);
         pz_ff   <= P_W'(in_ray.origin_z) - P_W'(center_z);
         r1_ff   <= radius;
      end
   end

   // stage 2
   assign pdx_in = PD_W'(px_ff) * PD_W'(ray1_ff.dir_x);
   assign pdy_in = PD_W'(py_ff) * PD_W'(ray1_ff.dir_y);
   assign pdz_in = PD_W'(pz_ff) * PD_W'(ray1_ff.dir_z);
   assign ppx_in = PP_W'(px_ff) * PP_W'(px_ff);
   assign ppy_in = PP_W'(py_ff) * PP_W'(py_ff);
   assign ppz_in = PP_W'(pz_ff) * PP_W'(pz_ff);
   assign rr_in  = RR_W'(r1_ff) * RR_W'(r1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ray2_ff <= ray1_ff;
         pdx_ff  <= pdx_in;
         pdy_ff  <= pdy_in;
         pdz_ff  <= pdz_in;
         ppx_ff  <= ppx_in;
         ppy_ff  <= ppy_in;
         ppz_ff  <= ppz_in;
         rr_ff   <= rr_in;
      end
   end

   // stage 3: s = p.d and cc = p.p - r*r
   assign s3_in  = S_W'(pdx_ff) + S_W'(pdy_ff) + S_W'(pdz_ff);
   assign cc3_in = CC_W'(ppx_ff) + CC_W'(ppy_ff) + CC_W'(ppz_ff)
                   - $signed({{(CC_W-RR_W){1'b0}}, rr_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         ray3_ff <= ray2_ff;
         s3_ff   <= s3_in;
         cc3_ff  <= cc3_in;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (en) begin
         ray4_ff <= ray3_ff;
         s4_ff   <= s3_ff;
         cc4_ff  <= cc3_ff;
         sabs_ff <= s3_ff[S_W-1] ? S_W'(-s3_ff) : S_W'(s3_ff);
      end
   end

   // stage 5: s * s as three partial products
   assign s_lo = sabs_ff[SLO_W-1:0];
   assign s_hi = sabs_ff[S_W-1:SLO_W];

   always_ff @(posedge clock) begin
      if (en) begin
         ray5_ff <= ray4_ff;
         s5_ff   <= s4_ff;
         cc5_ff  <= cc4_ff;
         ll_ff   <= (2*SLO_W)'(s_lo) * (2*SLO_W)'(s_lo);
         lh_ff   <= (SLO_W+SHI_W)'(s_lo) * (SLO_W+SHI_W)'(s_hi);
         hh_ff   <= (2*SHI_W)'(s_hi) * (2*SHI_W)'(s_hi);
      end
   end

   // stage 6: disc = s*s - cc * 2^(2*DIR)
   assign ss_sum  = (DISC_W'(hh_ff) << (2*SLO_W)) + (DISC_W'(lh_ff) << (SLO_W+1))
                    + DISC_W'(ll_ff);
   assign cc_sh   = DISC_W'(cc5_ff) <<< (2*DIR_FRAC_BITS);
   assign disc_in = $signed(ss_sum) - cc_sh;

   always_ff @(posedge clock) begin
      if (en) begin
         item6_ff.ray  <= ray5_ff;
         item6_ff.s    <= s5_ff;
         item6_ff.miss <= disc_in[DISC_W-1];
         rad6_ff       <= disc_in[DISC_W-1] ? '0 : disc_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_item  = item6_ff;
   assign out_rad   = rad6_ff;

endmodule

`default_nettype wire

// ===== sv/rsi_isqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_isqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence on two radicand bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_isqrt import rsi_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire item_type          in_item,
   input  wire logic [DISC_W-1:0] in_rad,
   output logic                   out_valid,
   output item_type               out_item,
   output logic [Q_W-1:0]         out_root
);

   // stage k reads cur_*[k] and writes *_ff[k+1]
   logic              valid_ff [1:Q_W];
   item_type          item_ff  [1:Q_W];
   logic [DISC_W-1:0] rad_ff   [1:Q_W];
   logic [REM_W-1:0]  rem_ff   [1:Q_W];
   logic [Q_W-1:0]    root_ff  [1:Q_W];

   logic              cur_valid [0:Q_W-1];
   item_type          cur_item  [0:Q_W-1];
   logic [DISC_W-1:0] cur_rad   [0:Q_W-1];
   logic [REM_W-1:0]  cur_rem   [0:Q_W-1];
   logic [Q_W-1:0]    cur_root  [0:Q_W-1];

   assign cur_valid[0] = in_valid;
   assign cur_item[0]  = in_item;
   assign cur_rad[0]   = in_rad;
   assign cur_rem[0]   = '0;
   assign cur_root[0]  = '0;

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [REM_W-1:0] acc;
      logic [REM_W-1:0] trial;
      logic             take;

      if (k > 0) begin : g_link
         assign cur_valid[k] = valid_ff[k];
         assign cur_item[k]  = item_ff[k];
         assign cur_rad[k]   = rad_ff[k];
         assign cur_rem[k]   = rem_ff[k];
         assign cur_root[k]  = root_ff[k];
      end

      // bring down two radicand bits, try root*4+1
      assign acc   = {cur_rem[k][REM_W-3:0], cur_rad[k][DISC_W-1 -: 2]};
      assign trial = {1'b0, cur_root[k], 2'b01};
      assign take  = (acc >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= cur_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[k+1] <= cur_item[k];
            rad_ff[k+1]  <= cur_rad[k] << 2;
            rem_ff[k+1]  <= take ? (acc - trial) : acc;
            root_ff[k+1] <= {cur_root[k][Q_W-2:0], take};
         end
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_item  = item_ff[Q_W];
   assign out_root  = root_ff[Q_W];

endmodule

`default_nettype wire

// ===== sv/rsi_finish.sv =====
// ----------------------------------------------------------------------------
// rsi_finish: root selection, hit point and output register
// Roots, window test, t * d products, then sum, saturation into the output.
// Also produces the pipeline advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_finish import rsi_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire item_type              in_item,
   input  wire logic [Q_W-1:0]        in_root,
   input  wire logic                  rsp_ready,
   output logic                       en,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [DIST_W-1:0]          rsp_dist,
   output logic signed [POS_W-1:0]    rsp_px,
   output logic signed [POS_W-1:0]    rsp_py,
   output logic signed [POS_W-1:0]    rsp_pz
);

   // stage 1: both roots
   logic                   v1_ff;
   item_type               item1_ff;
   logic signed [RT_W-1:0] rt0_ff, rt1_ff;
   // stage 2: window test
   logic                   v2_ff;
   ray_type                ray2_ff;
   logic                   hit2_ff;
   logic [DIST_W-1:0]      t2_ff;
   // stage 3: t * d
   logic                   v3_ff;
   ray_type                ray3_ff;
   logic                   hit3_ff;
   logic [DIST_W-1:0]      t3_ff;
   logic signed [TD_W-1:0] tdx_ff, tdy_ff, tdz_ff;
   // output register
   logic                   out_valid_ff;
   logic                   out_hit_ff;
   logic [DIST_W-1:0]      out_dist_ff;
   logic signed [POS_W-1:0] out_px_ff, out_py_ff, out_pz_ff;

   logic signed [NA_W-1:0]  na, fa;
   logic signed [RT_W-1:0]  near_s, far_s;
   logic                    in0, in1;
   logic signed [TD_W-1:0]  t_s;
   logic signed [ACC_W-1:0] accx, accy, accz;
   logic                    load;
   logic                    out_valid_in;

   // advance unless a finished word is blocked at the output and stage 3 holds a ray
   assign en   = !out_valid_ff || rsp_ready || !v3_ff;
   assign load = en && v3_ff;
   assign out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (en) begin
            v1_ff <= in_valid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end
   end

   // stage 1: floor((-s -/+ q) / 2^DIR)
   assign na = -NA_W'(in_item.s) - $signed({2'b00, in_root});
   assign fa = -NA_W'(in_item.s) + $signed({2'b00, in_root});

   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff <= in_item;
         rt0_ff   <= na[NA_W-1:DIR_FRAC_BITS];
         rt1_ff   <= fa[NA_W-1:DIR_FRAC_BITS];
      end
   end

   // stage 2: near root first, then far root
   assign near_s = $signed({{(RT_W-DIST_W){1'b0}}, item1_ff.ray.near_dist});
   assign far_s  = $signed({{(RT_W-DIST_W){1'b0}}, item1_ff.ray.far_dist});
   assign in0    = (rt0_ff >= near_s) && (rt0_ff <= far_s);
   assign in1    = (rt1_ff >= near_s) && (rt1_ff <= far_s);

   always_ff @(posedge clock) begin
      if (en) begin
         ray2_ff <= item1_ff.ray;
         hit2_ff <= !item1_ff.miss && (in0 || in1);
         t2_ff   <= in0 ? rt0_ff[DIST_W-1:0] : rt1_ff[DIST_W-1:0];
      end
   end

   // stage 3: t * d
   assign t_s = $signed({{(TD_W-DIST_W){1'b0}}, t2_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         ray3_ff <= ray2_ff;
         hit3_ff <= hit2_ff;
         t3_ff   <= t2_ff;
         tdx_ff  <= t_s * TD_W'(ray2_ff.dir_x);
         tdy_ff  <= t_s * TD_W'(ray2_ff.dir_y);
         tdz_ff  <= t_s * TD_W'(ray2_ff.dir_z);
      end
   end

   // output: o * 2^DIR + t * d, floor shift, saturate
   assign accx = (ACC_W'(ray3_ff.origin_x) <<< DIR_FRAC_BITS) + ACC_W'(tdx_ff);
   assign accy = (ACC_W'(ray3_ff.origin_y) <<< DIR_FRAC_BITS) + ACC_W'(tdy_ff);
   assign accz = (ACC_W'(ray3_ff.origin_z) <<< DIR_FRAC_BITS) + ACC_W'(tdz_ff);

   always_ff @(posedge clock) begin
      if (load) begin
         out_hit_ff  <= hit3_ff;
         out_dist_ff <= hit3_ff ? t3_ff : '0;
         out_px_ff   <= hit3_ff ? sat_pos(accx[ACC_W-1:DIR_FRAC_BITS]) : '0;
         out_py_ff   <= hit3_ff ? sat_pos(accy[ACC_W-1:DIR_FRAC_BITS]) : '0;
         out_pz_ff   <= hit3_ff ? sat_pos(accz[ACC_W-1:DIR_FRAC_BITS]) : '0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_hit   = out_hit_ff;
   assign rsp_dist  = out_dist_ff;
   assign rsp_px    = out_px_ff;
   assign rsp_py    = out_py_ff;
   assign rsp_pz    = out_pz_ff;

endmodule

`default_nettype wire

// ===== sv/ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect: fixed-point ray/sphere intersection
// One ray in per cycle while the pipeline does not stall; hit flag, distance and hit point out.
//
// Usage:
//  - req_ stream: one ray per word (origin Q16.16, unit direction Q2.14,
//    near and far distance). rsp_ stream: one word per ray, in order;
//    tuser is the hit flag, tdata carries distance and hit point (zero on a
//    miss).
//  - csr_ port: sphere center x/y/z and radius; write only while idle.
//  - Throughput: one ray per cycle unless stalled. Depth: 62 register stages
//    (6 discriminant stages, 52 square-root stages, one per root bit,
//    3 root-select and hit-point stages, output register).
//  - Stall: while a word waits in the output register, internal bubbles
//    still close up and req_tready stays high until the stage in front of
//    the output holds a ray; then the whole pipeline holds.
//  - Reset clears all valid bits; the center resets to the origin and the
//    radius to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect import rsi_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // ray stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, near_dist, far_dist
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // hit_dist, point_x, point_y, point_z
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // hit
   output logic                       rsp_tuser,
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic signed [POS_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [DIST_W-1:0]       radius_ff;
   logic                    csr_wr;
   reg_index_type           csr_idx;

   ray_type                 ray;
   logic                    en;
   logic                    setup_valid;
   item_type                setup_item;
   logic [DISC_W-1:0]       setup_rad;
   logic                    sqrt_valid;
   item_type                sqrt_item;
   logic [Q_W-1:0]          sqrt_root;
   logic                    hit;
   logic [DIST_W-1:0]       hit_dist;
   logic signed [POS_W-1:0] px, py, pz;

   // register port
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= RADIUS_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CENTER_X: begin
               center_x_ff <= csr_pwdata;
            end
            REG_CENTER_Y: begin
               center_y_ff <= csr_pwdata;
            end
            REG_CENTER_Z: begin
               center_z_ff <= csr_pwdata;
            end
            REG_RADIUS: begin
               radius_ff <= csr_pwdata[DIST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CENTER_X: csr_prdata = center_x_ff;
         REG_CENTER_Y: csr_prdata = center_y_ff;
         REG_CENTER_Z: csr_prdata = center_z_ff;
         REG_RADIUS:   csr_prdata = {1'b0, radius_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // unpack the ray word
   assign ray.origin_x  = req_tdata[0 +: POS_W];
   assign ray.origin_y  = req_tdata[POS_W +: POS_W];
   assign ray.origin_z  = req_tdata[2*POS_W +: POS_W];
   assign ray.dir_x     = req_tdata[3*POS_W +: DIR_W];
   assign ray.dir_y     = req_tdata[3*POS_W+DIR_W +: DIR_W];
   assign ray.dir_z     = req_tdata[3*POS_W+2*DIR_W +: DIR_W];
   assign ray.near_dist = req_tdata[3*POS_W+3*DIR_W +: DIST_W];
   assign ray.far_dist  = req_tdata[3*POS_W+3*DIR_W+DIST_W +: DIST_W];

   assign req_tready = en;

   rsi_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_ray    (ray),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .radius    (radius_ff),
      .out_valid (setup_valid),
      .out_item  (setup_item),
      .out_rad   (setup_rad)
   );

   rsi_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (setup_valid),
      .in_item   (setup_item),
      .in_rad    (setup_rad),
      .out_valid (sqrt_valid),
      .out_item  (sqrt_item),
      .out_root  (sqrt_root)
   );

   rsi_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_item   (sqrt_item),
      .in_root   (sqrt_root),
      .rsp_ready (rsp_tready),
      .en        (en),
      .rsp_valid (rsp_tvalid),
      .rsp_hit   (hit),
      .rsp_dist  (hit_dist),
      .rsp_px    (px),
      .rsp_py    (py),
      .rsp_pz    (pz)
   );

   // pack the result word
   assign rsp_tuser = hit;
   assign rsp_tdata = {{(RSP_DATA_W-RSP_BITS){1'b0}}, pz, py, px, hit_dist};

endmodule

`default_nettype wire

// ===== sv/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for the intersector
// Output hold under stall, miss encoding, reset behavior, register readback.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_checker import rsi_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  csr_psel,
   input wire logic                  csr_penable,
   input wire logic                  csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [CSR_DATA_W-1:0] csr_prdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a miss carries all-zero distance and point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss word not zero");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // center x reads back what was just written
   a_readback: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(csr_psel && csr_penable && csr_pwrite && csr_paddr == '0)
      && csr_paddr == '0 |-> csr_prdata == $past(csr_pwdata))
      else $error("center x readback mismatch");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire

// ===== sim/ray_sphere_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect_tb: self-checking regression for the ray intersector
// Walks a short table of directed rays, then streams random rays (mostly
// aimed at the sphere) under several sphere settings and idle patterns.
// Every result word is compared field by field with a typed-in answer or a fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_tb;
   import rsi_pkg::*;

   // One result word as the predictor sees it
   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] hit_dist;
      logic [POS_W-1:0]  px;
      logic [POS_W-1:0]  py;
      logic [POS_W-1:0]  pz;
   } hit_type;

   // Directed row: ray plus an optional typed-in answer
   typedef struct {
      ray_type ray;
      bit      known;
      hit_type answer;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ray_sphere_intersect u_top (.*);

   // Sphere as the predictor knows it
   longint sph_cx, sph_cy, sph_cz, sph_r;

   hit_type pending_hits[$];
   int      n_errors;
   int      n_rays;
   int      n_hits;
   int      n_words;
   int      send_idle;
   int      recv_idle;
   int      hold_cycles;
   bit      hold_req;

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Intersection predictor in fixed point
   function automatic hit_type intersect_ray(ray_type r);
      hit_type               h;
      longint                o[3], d[3], p[3], c[3];
      longint                s, t, rt0, rt1, acc, v, nearv, farv;
      logic signed [127:0]   pw, cc, sw, disc;
      logic [127:0]          sq;
      longint unsigned       q, cb;
      bit                    got;
      h = '0;
      o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
      d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
      c[0] = sph_cx;     c[1] = sph_cy;     c[2] = sph_cz;
      nearv = r.near_dist;
      farv  = r.far_dist;
      s  = 0;
      cc = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = o[i] - c[i];
         s += p[i] * d[i];
         pw = p[i];
         cc += pw * pw;
      end
      pw = sph_r;
      cc -= pw * pw;
      sw = s;
      disc = sw * sw - (cc <<< (2 * DIR_FRAC_BITS));
      if (disc < 0) return h;
      q = 0;
      for (int k = 63; k >= 0; k--) begin
         cb = q | (64'd1 << k);
         sq = 128'(cb) * 128'(cb);
         if (sq <= $unsigned(disc)) q = cb;
      end
      rt0 = (-s - longint'(q)) >>> DIR_FRAC_BITS;
      rt1 = (-s + longint'(q)) >>> DIR_FRAC_BITS;
      got = 1'b0;
      if (rt0 >= nearv && rt0 <= farv) begin
         t = rt0; got = 1'b1;
      end else if (rt1 >= nearv && rt1 <= farv) begin
         t = rt1; got = 1'b1;
      end
      if (!got) return h;
      h.hit      = 1'b1;
      h.hit_dist = t[DIST_W-1:0];
      for (int i = 0; i < 3; i++) begin
         acc = o[i] * (64'sd1 <<< DIR_FRAC_BITS) + t * d[i];
         v = acc >>> DIR_FRAC_BITS;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         if (i == 0) h.px = v[31:0];
         else if (i == 1) h.py = v[31:0];
         else h.pz = v[31:0];
      end
      return h;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want, n_words);
      n_errors++;
   endtask

   // ----------------------------------------------------- result checking
   always @(posedge clock) begin
      hit_type g, w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g.hit      = rsp_tuser;
         g.hit_dist = rsp_tdata[30:0];
         g.px       = rsp_tdata[62:31];
         g.py       = rsp_tdata[94:63];
         g.pz       = rsp_tdata[126:95];
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected word", g.hit_dist, 0);
         end else begin
            w = pending_hits.pop_front();
            if (g.hit != w.hit) report_mismatch("hit", g.hit, w.hit);
            if (g.hit_dist != w.hit_dist) report_mismatch("hit_dist", g.hit_dist, w.hit_dist);
            if (g.px != w.px) report_mismatch("point_x", g.px, w.px);
            if (g.py != w.py) report_mismatch("point_y", g.py, w.py);
            if (g.pz != w.pz) report_mismatch("point_z", g.pz, w.pz);
            if (w.hit) n_hits++;
         end
         n_words++;
      end
   end

   // ---------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req || hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         if (hold_req) begin
            hold_cycles = 400;
            hold_req = 1'b0;
         end else begin
            hold_cycles--;
         end
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Register write, setup then access phase
   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_CENTER_X: sph_cx = longint'($signed(val));
         REG_CENTER_Y: sph_cy = longint'($signed(val));
         REG_CENTER_Z: sph_cz = longint'($signed(val));
         REG_RADIUS:   sph_r  = longint'(val[30:0]);
         default:      ;
      endcase
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_RADIUS, rad);
   endtask

   // Drive one ray word; returns after it was accepted
   task automatic send_ray(ray_type r);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.far_dist, r.near_dist, r.dir_z, r.dir_y, r.dir_x,
                     r.origin_z, r.origin_y, r.origin_x};
      do @(posedge clock); while (!req_tready);
      pending_hits.push_back(intersect_ray(r));
      n_rays++;
      @(negedge clock);
   endtask

   // Wait for every result, then let the pipeline settle
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic longint near_sphere(longint c);
      return c + $signed($urandom_range(32'h0060_0000)) - 64'sh30_0000;
   endfunction

   // Random ray: mostly aimed at the sphere, the rest noise
   function automatic ray_type random_ray();
      ray_type r;
      real     vx, vy, vz, len;
      longint  ox, oy, oz;
      int      kind;
      kind = $urandom_range(99);
      r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom});
      if (kind < 15) return r;
      ox = near_sphere(sph_cx);
      oy = near_sphere(sph_cy);
      oz = near_sphere(sph_cz);
      r.origin_x = ox[31:0];
      r.origin_y = oy[31:0];
      r.origin_z = oz[31:0];
      vx = real'(sph_cx - ox) + ($urandom_range(2000) - 1000.0) * 256.0;
      vy = real'(sph_cy - oy) + ($urandom_range(2000) - 1000.0) * 256.0;
      vz = real'(sph_cz - oz) + ($urandom_range(2000) - 1000.0) * 256.0;
      if (kind < 30) begin
         vx = $urandom_range(2000) - 1000.0;
         vy = $urandom_range(2000) - 1000.0;
         vz = $urandom_range(2000) - 1000.0;
      end
      len = $sqrt(vx * vx + vy * vy + vz * vz);
      if (len < 1.0) begin
         vx = 0.0; vy = 0.0; vz = 1.0; len = 1.0;
      end
      r.dir_x = DIR_W'($rtoi(vx / len * 16384.0));
      r.dir_y = DIR_W'($rtoi(vy / len * 16384.0));
      r.dir_z = DIR_W'($rtoi(vz / len * 16384.0));
      if (kind < 70) begin
         r.near_dist = '0;
         r.far_dist  = {DIST_W{1'b1}};
      end else if (kind < 90) begin
         r.near_dist = DIST_W'($urandom_range(32'h0004_0000));
         r.far_dist  = DIST_W'($urandom_range(32'h0100_0000));
      end
      return r;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 && count > 100) hold_req = 1'b1;
         send_ray(random_ray());
      end
      drain();
   endtask

   // -------------------------------------------------------------- main
   initial begin
      row_type rows[$];
      row_type row;
      hit_type h;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      n_errors = 0;
      n_rays = 0;
      n_hits = 0;
      n_words = 0;
      send_idle = 23;
      recv_idle = 50;
      hold_cycles = 0;
      hold_req = 1'b0;
      sph_cx = 0;
      sph_cy = 0;
      sph_cz = 0;
      sph_r = 65536;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, reset sphere: unit radius at origin
      row = '{default: '0};
      row.ray = '{origin_x: -32'sd196608, dir_x: 16'sd16384, far_dist: '1, default: '0};
      row.known = 1'b1;
      row.answer = '{hit: 1'b1, hit_dist: 31'd131072, px: -32'sd65536, default: '0};
      rows.push_back(row);
      // miss: passes beside the sphere
      row.ray = '{origin_x: -32'sd196608, origin_y: 32'sd131072, dir_x: 16'sd16384,
                  far_dist: '1, default: '0};
      row.answer = '0;
      rows.push_back(row);
      // empty window: near above far
      row.ray = '{origin_x: -32'sd196608, dir_x: 16'sd16384, near_dist: 31'd10,
                  far_dist: 31'd5, default: '0};
      rows.push_back(row);
      // tangent ray grazing the top
      row.ray = '{origin_x: -32'sd196608, origin_y: 32'sd65536, dir_x: 16'sd16384,
                  far_dist: '1, default: '0};
      row.known = 1'b0;
      rows.push_back(row);
      // origin inside: near root behind, far root taken
      row.ray = '{dir_z: 16'sd16384, far_dist: '1, default: '0};
      rows.push_back(row);
      // window cuts off both roots
      row.ray = '{origin_x: -32'sd196608, dir_x: 16'sd16384, near_dist: 31'd400000,
                  far_dist: '1, default: '0};
      rows.push_back(row);
      // extremes of every field
      row.ray = '{origin_x: 32'h8000_0000, origin_y: 32'h8000_0000, origin_z: 32'h8000_0000,
                  dir_x: 16'h8000, dir_y: 16'h8000, dir_z: 16'h8000,
                  near_dist: '0, far_dist: '1};
      rows.push_back(row);
      row.ray = '{origin_x: 32'h7fff_ffff, origin_y: 32'h7fff_ffff, origin_z: 32'h7fff_ffff,
                  dir_x: 16'h7fff, dir_y: 16'h7fff, dir_z: 16'h7fff,
                  near_dist: '1, far_dist: '1};
      rows.push_back(row);
      row.ray = '{origin_x: 32'h7fff_0000, dir_x: 16'hc000, dir_y: 16'h4000,
                  far_dist: '1, default: '0};
      rows.push_back(row);
      row.ray = '{origin_z: -32'sd655360, dir_z: 16'sd16384, dir_x: -16'sd16384,
                  far_dist: '1, default: '0};
      rows.push_back(row);
      row.ray = '{default: '0};
      rows.push_back(row);

      foreach (rows[i]) begin
         send_ray(rows[i].ray);
         if (rows[i].known) begin
            h = intersect_ray(rows[i].ray);
            if (h != rows[i].answer) report_mismatch("directed row", i, h.hit_dist);
            pending_hits[pending_hits.size() - 1] = rows[i].answer;
         end
      end
      drain();

      // Random rays over several sphere settings and idle patterns
      random_phase(200);
      set_sphere($urandom_range(32'h0010_0000) - 32'h0008_0000,
                 $urandom_range(32'h0010_0000) - 32'h0008_0000,
                 $urandom_range(32'h0010_0000) - 32'h0008_0000,
                 $urandom_range(32'h0004_0000, 32'h0000_4000));
      random_phase(350);
      send_idle = 50;
      recv_idle = 23;
      set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_0000, 32'h7fff_ffff);
      random_phase(250);
      set_sphere($urandom, $urandom, $urandom, 32'h0);
      random_phase(250);
      send_idle = 0;
      recv_idle = 0;
      set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
      random_phase(200);
      set_sphere($urandom, $urandom, $urandom, $urandom);
      random_phase(100);
      set_sphere($urandom_range(32'h0004_0000) - 32'h0002_0000, 32'h0,
                 32'h0001_0000, $urandom_range(32'h0008_0000, 32'h0001_0000));
      random_phase(350);

      $display("covered %0d rays, %0d words checked, %0d hits, seven sphere settings",
               n_rays, n_words, n_hits);
      $display("idle patterns: sender-heavy, receiver-heavy, none; long output stalls");
      if (n_errors == 0 && pending_hits.size() == 0) begin
         $display("ray_sphere_intersect regression: pass");
      end else begin
         $display("ray_sphere_intersect regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(20 * 600000);
      $display("timeout waiting for results");
      $display("ray_sphere_intersect regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
